// ----- hw/rtl/sws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and register indexes for the sample window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_WR,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_DIV,
    S_OUT
  } state_t;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;

  localparam logic [14:0] RANGE_LOW_RST  = 15'd10;
  localparam logic [14:0] RANGE_HIGH_RST = 15'd90;

endpackage

// ----- hw/rtl/sample_window_statistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_window_statistics
// Sorted-window statistics: count, min, max, mean and median of a window,
// plus a range check and an overflow flag.
// An item is taken when start is high and busy is low. A negative sample is
// dropped, and so is a sample that arrives when the window is full, which sets
// overflow; every other sample is inserted in order into an internal memory.
// The insertion walks down from the top of the window, spending a read state
// and a compare state on each stored sample larger than the new one, which it
// moves up, and then writes the new sample. A dropped or ignored sample that
// does not end the window leaves busy low.
// When last is set, the block reads min, max and the middle elements in the
// states S_M0 to S_M4 and then runs a restoring divider one quotient bit per
// cycle for the mean; the dividend is QW bits wide (25 at the default depth).
// An empty window skips the reads and the divider and shows its result in the
// next cycle.
// The result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall it. Range registers are written on the cfg channel, which is
// always ready and must only be used while busy is low.
// Reset clears the window and loads the range registers with 10 and 90.
// ----------------------------------------------------------------------------
module sample_window_statistics #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               out_valid,
  output logic [5:0]         out_valid_count,
  output logic [14:0]        out_min_value,
  output logic [14:0]        out_max_value,
  output logic [18:0]        out_mean_x16,
  output logic [15:0]        out_median_x2,
  output logic               out_all_in_range,
  output logic               out_empty_res,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int SW  = 15 + CW;
  localparam int QW  = SW + 4;
  localparam int DCW = $clog2(QW + 1);

  sws_pkg::state_t state_r, state_nxt;

  logic [14:0]   mem [MAX_SAMPLES];
  logic [14:0]   rdata_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [14:0]   wr_data;
  logic          wr_en;

  logic [14:0]    range_low_r, range_high_r;
  logic [CW-1:0]  count_r;
  logic [SW-1:0]  sum_r;
  logic           range_ok_r, ovf_r;
  logic [14:0]    v_r;
  logic           last_r;
  logic [AW-1:0]  pos_r;
  logic [14:0]    min_r, max_r, lo_r, hi_r;
  logic [CW-1:0]  rem_r;
  logic [QW-1:0]  quo_r;
  logic [DCW-1:0] div_cnt_r;

  logic          accept;
  logic          keep;
  logic [CW:0]   trial;
  logic          ge;
  logic          is_empty;
  logic [15:0]   median;

  assign accept    = start && !busy;
  assign keep      = !in_sample[15];
  assign cfg_ready = 1'b1;
  assign trial     = {rem_r, quo_r[QW-1]};
  assign ge        = trial >= {1'b0, count_r};
  assign is_empty  = count_r == '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sws_pkg::S_IDLE: begin
        if (accept) begin
          if (keep && count_r < CW'(MAX_SAMPLES)) begin
            state_nxt = (count_r == '0) ? sws_pkg::S_WR : sws_pkg::S_RD;
          end else if (in_last) begin
            state_nxt = (count_r == '0) ? sws_pkg::S_OUT : sws_pkg::S_M0;
          end
        end
      end
      sws_pkg::S_RD:  state_nxt = sws_pkg::S_CMP;
      sws_pkg::S_CMP: begin
        if (rdata_r > v_r && pos_r != AW'(1)) begin
          state_nxt = sws_pkg::S_RD;
        end else begin
          state_nxt = sws_pkg::S_WR;
        end
      end
      sws_pkg::S_WR:  state_nxt = last_r ? sws_pkg::S_M0 : sws_pkg::S_IDLE;
      sws_pkg::S_M0:  state_nxt = sws_pkg::S_M1;
      sws_pkg::S_M1:  state_nxt = sws_pkg::S_M2;
      sws_pkg::S_M2:  state_nxt = sws_pkg::S_M3;
      sws_pkg::S_M3:  state_nxt = sws_pkg::S_M4;
      sws_pkg::S_M4:  state_nxt = sws_pkg::S_DIV;
      sws_pkg::S_DIV: state_nxt = (div_cnt_r == DCW'(1)) ? sws_pkg::S_OUT : sws_pkg::S_DIV;
      sws_pkg::S_OUT: state_nxt = sws_pkg::S_IDLE;
      default:        state_nxt = sws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = v_r;
    case (state_r)
      sws_pkg::S_RD: rd_addr = pos_r - 1'b1;
      sws_pkg::S_CMP: begin
        if (rdata_r > v_r) begin
          wr_en   = 1'b1;
          wr_data = rdata_r;
        end
      end
      sws_pkg::S_WR:  wr_en = 1'b1;
      sws_pkg::S_M0:  rd_addr = '0;
      sws_pkg::S_M1:  rd_addr = AW'(count_r - 1'b1);
      sws_pkg::S_M2:  rd_addr = AW'(count_r >> 1) - 1'b1;
      sws_pkg::S_M3:  rd_addr = AW'(count_r >> 1);
      default:        rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sws_pkg::S_IDLE;
      range_low_r  <= sws_pkg::RANGE_LOW_RST;
      range_high_r <= sws_pkg::RANGE_HIGH_RST;
      count_r      <= '0;
      sum_r        <= '0;
      range_ok_r   <= 1'b1;
      ovf_r        <= 1'b0;
      last_r       <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sws_pkg::REG_RANGE_LOW) begin
          range_low_r <= cfg_data;
        end else if (cfg_index == sws_pkg::REG_RANGE_HIGH) begin
          range_high_r <= cfg_data;
        end
      end
      case (state_r)
        sws_pkg::S_IDLE: begin
          if (accept) begin
            last_r <= in_last;
            v_r    <= in_sample[14:0];
            pos_r  <= AW'(count_r);
            if (keep && count_r >= CW'(MAX_SAMPLES)) begin
              ovf_r <= 1'b1;
            end
          end
        end
        sws_pkg::S_CMP: begin
          if (rdata_r > v_r) begin
            pos_r <= pos_r - 1'b1;
          end
        end
        sws_pkg::S_WR: begin
          count_r <= count_r + 1'b1;
          sum_r   <= sum_r + SW'(v_r);
          if (v_r < range_low_r || v_r > range_high_r) begin
            range_ok_r <= 1'b0;
          end
        end
        sws_pkg::S_M0: begin
          quo_r     <= {sum_r, 4'b0000};
          rem_r     <= '0;
          div_cnt_r <= DCW'(QW);
        end
        sws_pkg::S_M1: min_r <= rdata_r;
        sws_pkg::S_M2: max_r <= rdata_r;
        sws_pkg::S_M3: lo_r  <= rdata_r;
        sws_pkg::S_M4: hi_r  <= rdata_r;
        sws_pkg::S_DIV: begin
          rem_r     <= ge ? CW'(trial - {1'b0, count_r}) : CW'(trial);
          quo_r     <= {quo_r[QW-2:0], ge};
          div_cnt_r <= div_cnt_r - 1'b1;
        end
        sws_pkg::S_OUT: begin
          count_r    <= '0;
          sum_r      <= '0;
          range_ok_r <= 1'b1;
          ovf_r      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign median = count_r[0] ? {hi_r, 1'b0} : (16'(lo_r) + 16'(hi_r));

  assign busy             = state_r != sws_pkg::S_IDLE;
  assign out_valid        = state_r == sws_pkg::S_OUT;
  assign out_valid_count  = 6'(count_r);
  assign out_min_value    = is_empty ? '0 : min_r;
  assign out_max_value    = is_empty ? '0 : max_r;
  assign out_mean_x16     = is_empty ? '0 : quo_r[18:0];
  assign out_median_x2    = is_empty ? '0 : median;
  assign out_all_in_range = range_ok_r;
  assign out_empty_res    = is_empty;
  assign out_overflow     = ovf_r;

endmodule

// ----- hw/rtl/sws_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks on the result beats of the window statistics block.
// ----------------------------------------------------------------------------
module sws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [5:0]  out_valid_count,
  input logic [14:0] out_min_value,
  input logic [14:0] out_max_value,
  input logic [18:0] out_mean_x16,
  input logic        out_empty_res
);

  // A result beat never repeats in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result beat lasted more than one cycle");

  // A result beat is only produced while a window is being closed.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result beat while idle");

  // An empty window reports zero count and zero mean.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_valid_count == 6'd0 && out_mean_x16 == 19'd0)
    else $error("empty window with nonzero statistics");

  // The minimum of a non-empty window never exceeds its maximum.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> out_min_value <= out_max_value)
    else $error("minimum above maximum");

endmodule

bind sample_window_statistics sws_checker u_sws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_valid_count (out_valid_count),
  .out_min_value   (out_min_value),
  .out_max_value   (out_max_value),
  .out_mean_x16    (out_mean_x16),
  .out_empty_res   (out_empty_res)
);
